[rtl/cdr_pkg.sv]
// ----------------------------------------------------------------------------
// cdr_pkg
// Shared types and constants for the character display delta refresh unit.
// ----------------------------------------------------------------------------
package cdr_pkg;

   localparam int COLUMNS_DEF = 16;
   localparam int ROWS_DEF    = 2;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // command kinds on the result channel
   localparam logic CMD_POSITION = 1'b0;
   localparam logic CMD_CHAR     = 1'b1;

   typedef enum logic [2:0] {
      OP_PRINT      = 3'd0,
      OP_GOTO       = 3'd1,
      OP_CLEAR      = 3'd2,
      OP_UPDATE     = 3'd3,
      OP_UPDATE_ALL = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_CHR,
      S_CURSOR
   } seq_state_type;

   // sequencer to top: store strobes and status
   typedef struct packed {
      logic busy;
      logic rd_en;
      logic shown_wr;
   } scan_ctrl_type;

endpackage

[rtl/cdr_if.sv]
// ----------------------------------------------------------------------------
// cdr_if
// Valid/ready channels for requests and display commands.
// ----------------------------------------------------------------------------
interface cdr_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] char_code;
   logic [7:0] target_col;
   logic [7:0] target_row;

   modport source (output valid, opcode, char_code, target_col, target_row, input ready);
   modport sink   (input valid, opcode, char_code, target_col, target_row, output ready);
endinterface

interface cdr_rsp_if;
   logic       valid;
   logic       ready;
   logic       command_kind;
   logic [3:0] out_col;
   logic       out_row;
   logic [7:0] out_char;
   logic       cursor_off_screen;
   logic       last_command;

   modport source (output valid, command_kind, out_col, out_row, out_char,
                   cursor_off_screen, last_command, input ready);
   modport sink   (input valid, command_kind, out_col, out_row, out_char,
                   cursor_off_screen, last_command, output ready);
endinterface

[rtl/char_display_delta_refresh_unit.sv]
// ----------------------------------------------------------------------------
// char_display_delta_refresh_unit
// Double-buffered character display engine with delta refresh.
// ----------------------------------------------------------------------------
// Requests arrive on req_chan (valid/ready); display commands leave on
// rsp_chan (valid/ready), one command per transfer.
// Print, goto, clear and unknown opcodes produce no command; ready stays
// high, so the next request can follow at once.
// An update walks the cells in order through one comparator, one cell per
// cycle unless a command is held up; each position command, i.e. each run
// of changed cells, goes out ahead of the character of its first cell and
// holds the walk on that cell; at most half a row (rounded up) per row.
// Update-all sends one position command per row. Ready is low for the
// whole walk.
// Commands sit in one output register; a stalled receiver holds the walk on
// a cell that needs a command, and a print, goto or clear is still taken
// while the final command waits.
// Reset (synchronous) sets both stores to spaces at once through per-cell
// valid bits, homes the cursor and marks it valid; no clearing pass.
// ----------------------------------------------------------------------------
module char_display_delta_refresh_unit #(
   parameter int COLUMNS = cdr_pkg::COLUMNS_DEF,
   parameter int ROWS    = cdr_pkg::ROWS_DEF
) (
   input logic       clock,
   input logic       reset,
   cdr_req_if.sink   req_chan,
   cdr_rsp_if.source rsp_chan
);
   import cdr_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

   // write cursor, kept both as col/row and as a flat cell index
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [CELL_W-1:0] cur_idx_ff, cur_idx_in;
   logic              cur_valid_ff, cur_valid_in;

   scan_ctrl_type     ctrl;
   logic [CELL_W-1:0] rd_addr, wr_addr;
   logic [7:0]        text_q, shown_q;

   logic accept, do_print, do_clear, start, all_mode, goto_bad;

   assign req_chan.ready = !ctrl.busy;
   assign accept   = req_chan.valid && req_chan.ready;
   assign do_print = accept && req_chan.opcode == OP_PRINT && cur_valid_ff;
   assign do_clear = accept && req_chan.opcode == OP_CLEAR;
   assign start    = accept &&
                     (req_chan.opcode == OP_UPDATE || req_chan.opcode == OP_UPDATE_ALL);
   assign all_mode = (req_chan.opcode == OP_UPDATE_ALL);
   assign goto_bad = (req_chan.target_col >= 8'(COLUMNS)) ||
                     (req_chan.target_row >= 8'(ROWS));

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         cur_idx_ff   <= '0;
         cur_valid_ff <= 1'b1;
      end else begin
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         cur_idx_ff   <= cur_idx_in;
         cur_valid_ff <= cur_valid_in;
      end
   end

   always_comb begin
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      cur_idx_in   = cur_idx_ff;
      cur_valid_in = cur_valid_ff;
      if (accept) begin
         case (req_chan.opcode)
            OP_PRINT: begin
               // no wrap: the last column drops the cursor off screen
               if (cur_valid_ff) begin
                  if (cur_col_ff == COL_W'(COLUMNS - 1)) begin
                     cur_valid_in = 1'b0;
                  end else begin
                     cur_col_in = COL_W'(cur_col_ff + 1'b1);
                     cur_idx_in = CELL_W'(cur_idx_ff + 1'b1);
                  end
               end
            end
            OP_GOTO: begin
               if (goto_bad) begin
                  cur_valid_in = 1'b0;
               end else begin
                  cur_col_in   = req_chan.target_col[COL_W-1:0];
                  cur_row_in   = req_chan.target_row[ROW_W-1:0];
                  cur_idx_in   = CELL_W'(int'(req_chan.target_row) * COLUMNS +
                                         int'(req_chan.target_col));
                  cur_valid_in = 1'b1;
               end
            end
            OP_CLEAR: begin
               cur_col_in   = '0;
               cur_row_in   = '0;
               cur_idx_in   = '0;
               cur_valid_in = 1'b1;
            end
            default: begin
               // updates leave the cursor alone; unknown opcodes are ignored
            end
         endcase
      end
   end

   cdr_store #(
      .DEPTH  (CELLS),
      .ADDR_W (CELL_W)
   ) u_text_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (do_clear),
      .wr_en   (do_print),
      .wr_addr (cur_idx_ff),
      .wr_data (req_chan.char_code),
      .rd_en   (ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (text_q)
   );

   cdr_store #(
      .DEPTH  (CELLS),
      .ADDR_W (CELL_W)
   ) u_shown_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (1'b0),
      .wr_en   (ctrl.shown_wr),
      .wr_addr (wr_addr),
      .wr_data (text_q),
      .rd_en   (ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (shown_q)
   );

   cdr_seq #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .CELL_W  (CELL_W),
      .COL_W   (COL_W),
      .ROW_W   (ROW_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .all_mode  (all_mode),
      .cur_col   (cur_col_ff),
      .cur_row   (cur_row_ff),
      .cur_valid (cur_valid_ff),
      .text_q    (text_q),
      .shown_q   (shown_q),
      .ctrl      (ctrl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .rsp_chan  (rsp_chan)
   );

endmodule

[rtl/cdr_store.sv]
// ----------------------------------------------------------------------------
// cdr_store
// Character store: one write port, one registered read port, per-entry valid
// bits so that an unwritten or cleared entry reads as a space.
// ----------------------------------------------------------------------------
module cdr_store #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   import cdr_pkg::*;

   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [7:0]       rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : SPACE_CHAR;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cdr_seq.sv]
// ----------------------------------------------------------------------------
// cdr_seq
// Refresh sequencer: walks the cells, compares text against shown through one
// comparator and issues display commands into an output register.
// ----------------------------------------------------------------------------
module cdr_seq #(
   parameter int COLUMNS = cdr_pkg::COLUMNS_DEF,
   parameter int ROWS    = cdr_pkg::ROWS_DEF,
   parameter int CELL_W  = 5,
   parameter int COL_W   = 4,
   parameter int ROW_W   = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  all_mode,
   input  logic [COL_W-1:0]      cur_col,
   input  logic [ROW_W-1:0]      cur_row,
   input  logic                  cur_valid,
   input  logic [7:0]            text_q,
   input  logic [7:0]            shown_q,
   output cdr_pkg::scan_ctrl_type ctrl,
   output logic [CELL_W-1:0]     rd_addr,
   output logic [CELL_W-1:0]     wr_addr,
   cdr_rsp_if.source             rsp_chan
);
   import cdr_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   seq_state_type     state_ff, state_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              gap_ff, gap_in;
   logic              all_ff, all_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              kind_ff, orow_ff;
   logic [3:0]        ocol4_ff;
   logic [7:0]        ochar_ff;
   logic              off_ff, last_ff;

   logic              slot_free, emit, advance, differs;
   logic              e_kind, e_row, e_off, e_last;
   logic [3:0]        e_col;
   logic [7:0]        e_char;
   logic [7:0]        col_wide, row_wide, ccol_wide, crow_wide;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign differs   = all_ff || (text_q != shown_q);
   assign col_wide  = 8'(col_ff);
   assign row_wide  = 8'(row_ff);
   assign ccol_wide = 8'(cur_col);
   assign crow_wide = 8'(cur_row);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      gap_ff  <= gap_in;
      all_ff  <= all_in;
      if (emit) begin
         kind_ff  <= e_kind;
         ocol4_ff <= e_col;
         orow_ff  <= e_row;
         ochar_ff <= e_char;
         off_ff   <= e_off;
         last_ff  <= e_last;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cell_in       = cell_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      gap_in        = gap_ff;
      all_in        = all_ff;
      emit          = 1'b0;
      advance       = 1'b0;
      e_kind        = CMD_POSITION;
      e_col         = 4'd0;
      e_row         = 1'b0;
      e_char        = 8'd0;
      e_off         = 1'b0;
      e_last        = 1'b0;
      ctrl.busy     = (state_ff != S_IDLE);
      ctrl.rd_en    = 1'b0;
      ctrl.shown_wr = 1'b0;
      rd_addr       = cell_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cell_in    = '0;
               col_in     = '0;
               row_in     = '0;
               gap_in     = 1'b1;
               all_in     = all_mode;
               ctrl.rd_en = 1'b1;
               rd_addr    = '0;
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            if (!differs) begin
               gap_in  = 1'b1;
               advance = 1'b1;
            end else if (col_ff == '0 || gap_ff) begin
               if (slot_free) begin
                  emit     = 1'b1;
                  e_kind   = CMD_POSITION;
                  e_col    = col_wide[3:0];
                  e_row    = row_wide[0];
                  state_in = S_CHR;
               end
            end else if (slot_free) begin
               emit          = 1'b1;
               e_kind        = CMD_CHAR;
               e_char        = text_q;
               ctrl.shown_wr = 1'b1;
               gap_in        = 1'b0;
               advance       = 1'b1;
            end
         end
         S_CHR: begin
            if (slot_free) begin
               emit          = 1'b1;
               e_kind        = CMD_CHAR;
               e_char        = text_q;
               ctrl.shown_wr = 1'b1;
               gap_in        = 1'b0;
               advance       = 1'b1;
            end
         end
         S_CURSOR: begin
            if (slot_free) begin
               emit   = 1'b1;
               e_kind = CMD_POSITION;
               e_last = 1'b1;
               if (cur_valid) begin
                  e_col = ccol_wide[3:0];
                  e_row = crow_wide[0];
               end else begin
                  e_off = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (advance) begin
         if (cell_ff == CELL_W'(CELLS - 1)) begin
            state_in = S_CURSOR;
         end else begin
            cell_in    = CELL_W'(cell_ff + 1'b1);
            ctrl.rd_en = 1'b1;
            rd_addr    = CELL_W'(cell_ff + 1'b1);
            state_in   = S_CMP;
            if (col_ff == COL_W'(COLUMNS - 1)) begin
               col_in = '0;
               row_in = ROW_W'(row_ff + 1'b1);
            end else begin
               col_in = COL_W'(col_ff + 1'b1);
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign wr_addr   = cell_ff;

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.command_kind      = kind_ff;
   assign rsp_chan.out_col           = ocol4_ff;
   assign rsp_chan.out_row           = orow_ff;
   assign rsp_chan.out_char          = ochar_ff;
   assign rsp_chan.cursor_off_screen = off_ff;
   assign rsp_chan.last_command      = last_ff;

   a_cell_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.busy |-> cell_ff <= CELL_W'(CELLS - 1))
      else $error("cell counter out of range");

   a_off_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && off_ff |-> last_ff)
      else $error("off-screen flag on a command that is not final");

   a_start_scans: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && start |=> state_ff == S_CMP)
      else $error("update did not start the cell walk");

   a_copy_only_changed: assert property (@(posedge clock) disable iff (reset)
      ctrl.shown_wr |-> all_ff || text_q != shown_q)
      else $error("unchanged cell sent in a delta update");

endmodule
